>>> rtl/core/lhc_pkg.sv
// ----------------------------------------------------------------------------
// lhc_pkg
// Shared constants, codes and command word for the LRU handle cache.
// ----------------------------------------------------------------------------
package lhc_pkg;

   localparam int NumSlots   = 8;
   localparam int SlotW      = $clog2(NumSlots);
   localparam int CountW     = $clog2(NumSlots + 1);
   localparam int RankW      = SlotW;
   localparam int KeyW       = 32;
   localparam int QueueDepth = 2;

   localparam logic [CountW-1:0] CapReset = CountW'(NumSlots);

   typedef enum logic [1:0] {
      REQ_ACCESS = 2'd0,
      REQ_TRIM   = 2'd1,
      REQ_CLEAR  = 2'd2,
      REQ_NOP    = 2'd3
   } req_code_type;

   typedef enum logic [2:0] {
      RSP_EVICT     = 3'd0,
      RSP_HIT       = 3'd1,
      RSP_INSERT    = 3'd2,
      RSP_OPEN_FAIL = 3'd3,
      RSP_DONE      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_LOOKUP = 2'd1,
      ST_EXEC   = 2'd2
   } back_state_type;

   typedef struct packed {
      req_code_type      op;
      logic [KeyW-1:0]   key_x;
      logic [KeyW-1:0]   key_z;
      logic              open_ok;
   } cmd_type;

endpackage

>>> rtl/core/lru_handle_cache.sv
// ----------------------------------------------------------------------------
// lru_handle_cache
// Fully associative LRU cache of open handles keyed by a signed (x, z) pair.
// ----------------------------------------------------------------------------
// Request channel: a word (req_type, req_key_x, req_key_z, req_open_ok) is
// taken at a clock edge with start high and busy low. Access looks up the
// key; a hit moves it to most recent, a miss evicts oldest entries while the
// count is at or above capacity, then inserts the key if req_open_ok is set.
// Trim evicts down to capacity, clear empties the cache.
// Result channel: each result word shows on the rsp_ ports for one cycle with
// rsp_valid high; every eviction gives a word, and the final word of each
// request carries rsp_last. The receiver cannot stall; nothing holds results.
// The first result word passes the intake register, the command queue, the
// lookup state and the result register; each request then gives one word
// per cycle, one per eviction and a final word. A two-word command queue
// lets requests be taken while the engine works. The user must write
// capacity through csr_wr_en / csr_wr_data only while idle; the block does
// not enforce it. Reset empties the cache and sets capacity to eight entries.
// ----------------------------------------------------------------------------
module lru_handle_cache (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [1:0]                        req_type,
   input  logic signed [lhc_pkg::KeyW-1:0]   req_key_x,
   input  logic signed [lhc_pkg::KeyW-1:0]   req_key_z,
   input  logic                              req_open_ok,
   input  logic                              csr_wr_en,
   input  logic [lhc_pkg::CountW-1:0]        csr_wr_data,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [lhc_pkg::SlotW-1:0]         rsp_slot,
   output logic signed [lhc_pkg::KeyW-1:0]   rsp_out_x,
   output logic signed [lhc_pkg::KeyW-1:0]   rsp_out_z,
   output logic [lhc_pkg::CountW-1:0]        rsp_entry_count,
   output logic                              rsp_last
);

   logic             q_push, q_pop, q_full, q_empty;
   lhc_pkg::cmd_type q_in_cmd, q_head;

   lhc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_type    (req_type),
      .req_key_x   (req_key_x),
      .req_key_z   (req_key_z),
      .req_open_ok (req_open_ok),
      .q_full      (q_full),
      .busy        (busy),
      .push        (q_push),
      .push_cmd    (q_in_cmd)
   );

   lhc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_in_cmd),
      .pop      (q_pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (q_head)
   );

   lhc_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .q_empty         (q_empty),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_z       (rsp_out_z),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

endmodule

>>> rtl/core/lhc_front.sv
// ----------------------------------------------------------------------------
// lhc_front
// Request intake: decodes the request word and stages it for the queue.
// ----------------------------------------------------------------------------
module lhc_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [1:0]                     req_type,
   input  logic signed [lhc_pkg::KeyW-1:0] req_key_x,
   input  logic signed [lhc_pkg::KeyW-1:0] req_key_z,
   input  logic                           req_open_ok,
   input  logic                           q_full,
   output logic                           busy,
   output logic                           push,
   output lhc_pkg::cmd_type               push_cmd
);

   logic             valid_ff, valid_in;
   lhc_pkg::cmd_type cmd_ff, cmd_in;
   logic             take;

   assign busy     = valid_ff & q_full;
   assign take     = start & ~busy;
   assign push     = valid_ff & ~q_full;
   assign push_cmd = cmd_ff;

   always_comb begin
      cmd_in         = cmd_ff;
      cmd_in.op      = lhc_pkg::req_code_type'(req_type);
      cmd_in.key_x   = '0;
      cmd_in.key_z   = '0;
      cmd_in.open_ok = 1'b0;
      unique case (lhc_pkg::req_code_type'(req_type))
         lhc_pkg::REQ_ACCESS: begin
            cmd_in.key_x   = $unsigned(req_key_x);
            cmd_in.key_z   = $unsigned(req_key_z);
            cmd_in.open_ok = req_open_ok;
         end
         lhc_pkg::REQ_TRIM, lhc_pkg::REQ_CLEAR, lhc_pkg::REQ_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (push) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

>>> rtl/core/lhc_queue.sv
// ----------------------------------------------------------------------------
// lhc_queue
// Short command FIFO between request intake and the cache engine.
// ----------------------------------------------------------------------------
module lhc_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  lhc_pkg::cmd_type push_cmd,
   input  logic             pop,
   output logic             full,
   output logic             empty,
   output lhc_pkg::cmd_type head
);

   localparam int PtrW = (lhc_pkg::QueueDepth > 1) ? $clog2(lhc_pkg::QueueDepth) : 1;
   localparam int CntW = $clog2(lhc_pkg::QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(lhc_pkg::QueueDepth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(lhc_pkg::QueueDepth);

   lhc_pkg::cmd_type  mem_ff [lhc_pkg::QueueDepth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;

   assign full  = (count_ff == FullCnt);
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CntW'(1);
         2'b01:   count_in = count_ff - CntW'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/lhc_back.sv
// ----------------------------------------------------------------------------
// lhc_back
// Cache engine: tag lookup, recency update, eviction runs and result words.
// ----------------------------------------------------------------------------
module lhc_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [lhc_pkg::CountW-1:0]        csr_wr_data,
   input  logic                              q_empty,
   input  lhc_pkg::cmd_type                  q_head,
   output logic                              q_pop,
   output logic                              rsp_valid,
   output logic [2:0]                        rsp_status,
   output logic [lhc_pkg::SlotW-1:0]         rsp_slot,
   output logic signed [lhc_pkg::KeyW-1:0]   rsp_out_x,
   output logic signed [lhc_pkg::KeyW-1:0]   rsp_out_z,
   output logic [lhc_pkg::CountW-1:0]        rsp_entry_count,
   output logic                              rsp_last
);

   localparam int N  = lhc_pkg::NumSlots;
   localparam int SW = lhc_pkg::SlotW;
   localparam int CW = lhc_pkg::CountW;
   localparam int RW = lhc_pkg::RankW;
   localparam int KW = lhc_pkg::KeyW;
   localparam logic [CW-1:0] CapMax = CW'(N);

   lhc_pkg::back_state_type state_ff, state_in;
   lhc_pkg::cmd_type        cur_ff, cur_in;

   logic [KW-1:0] tag_x_ff [N];
   logic [KW-1:0] tag_z_ff [N];
   logic          tag_we;
   logic [SW-1:0] tag_idx;

   logic [N-1:0]  valid_ff, valid_in;
   logic [RW-1:0] rank_ff [N];
   logic [RW-1:0] rank_in [N];
   logic [CW-1:0] held_ff, held_in;
   logic [CW-1:0] cap_ff, cap_eff;

   logic          hit_ff, hit_in;
   logic [SW-1:0] hit_idx_ff, hit_idx_in;

   logic          m_found, f_found, v_found;
   logic [SW-1:0] m_idx, f_idx, v_idx;
   logic [RW-1:0] v_rank;
   logic          exec_done;

   logic               rsp_valid_ff, rsp_valid_in;
   lhc_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [SW-1:0]      rsp_slot_ff, rsp_slot_in;
   logic [KW-1:0]      rsp_x_ff, rsp_x_in;
   logic [KW-1:0]      rsp_z_ff, rsp_z_in;
   logic [CW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_slot        = rsp_slot_ff;
   assign rsp_out_x       = $signed(rsp_x_ff);
   assign rsp_out_z       = $signed(rsp_z_ff);
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   assign cap_eff = (cap_ff > CapMax) ? CapMax : cap_ff;

   always_comb begin
      m_found = 1'b0;
      m_idx   = '0;
      f_found = 1'b0;
      f_idx   = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && tag_x_ff[i] == cur_ff.key_x && tag_z_ff[i] == cur_ff.key_z) begin
            m_found = 1'b1;
            m_idx   = SW'(i);
         end
         if (!valid_ff[i]) begin
            f_found = 1'b1;
            f_idx   = SW'(i);
         end
      end
   end

   always_comb begin
      v_found = 1'b0;
      v_idx   = '0;
      v_rank  = '0;
      for (int i = 0; i < N; i++) begin
         if (valid_ff[i] && (!v_found || rank_ff[i] > v_rank)) begin
            v_found = 1'b1;
            v_idx   = SW'(i);
            v_rank  = rank_ff[i];
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lhc_pkg::ST_IDLE: begin
            if (!q_empty) begin
               state_in = lhc_pkg::ST_LOOKUP;
            end
         end
         lhc_pkg::ST_LOOKUP: begin
            state_in = lhc_pkg::ST_EXEC;
         end
         lhc_pkg::ST_EXEC: begin
            if (exec_done) begin
               state_in = q_empty ? lhc_pkg::ST_IDLE : lhc_pkg::ST_LOOKUP;
            end
         end
         default: begin
            state_in = lhc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cur_in        = cur_ff;
      q_pop         = 1'b0;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      valid_in      = valid_ff;
      rank_in       = rank_ff;
      held_in       = held_ff;
      tag_we        = 1'b0;
      tag_idx       = f_idx;
      exec_done     = 1'b0;
      rsp_valid_in  = 1'b0;
      rsp_status_in = lhc_pkg::RSP_DONE;
      rsp_slot_in   = '0;
      rsp_x_in      = '0;
      rsp_z_in      = '0;
      rsp_last_in   = 1'b1;
      rsp_count_in  = held_ff;

      unique case (state_ff)
         lhc_pkg::ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
            end
         end
         lhc_pkg::ST_LOOKUP: begin
            hit_in     = m_found;
            hit_idx_in = m_idx;
         end
         lhc_pkg::ST_EXEC: begin
            case (cur_ff.op)
               lhc_pkg::REQ_ACCESS: begin
                  if (hit_ff) begin
                     for (int i = 0; i < N; i++) begin
                        if (valid_ff[i] && rank_ff[i] < rank_ff[hit_idx_ff]) begin
                           rank_in[i] = rank_ff[i] + RW'(1);
                        end
                     end
                     rank_in[hit_idx_ff] = '0;
                     exec_done     = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lhc_pkg::RSP_HIT;
                     rsp_slot_in   = hit_idx_ff;
                     rsp_x_in      = cur_ff.key_x;
                     rsp_z_in      = cur_ff.key_z;
                  end else if (held_ff != '0 && held_ff >= cap_eff) begin
                     if (v_found) begin
                        valid_in[v_idx] = 1'b0;
                        rank_in[v_idx]  = '0;
                        held_in         = held_ff - CW'(1);
                        rsp_valid_in    = 1'b1;
                        rsp_status_in   = lhc_pkg::RSP_EVICT;
                        rsp_slot_in     = v_idx;
                        rsp_x_in        = tag_x_ff[v_idx];
                        rsp_z_in        = tag_z_ff[v_idx];
                        rsp_last_in     = 1'b0;
                        rsp_count_in    = held_in;
                     end else begin
                        held_in = '0;
                     end
                  end else if (cur_ff.open_ok && f_found) begin
                     for (int i = 0; i < N; i++) begin
                        if (valid_ff[i]) begin
                           rank_in[i] = rank_ff[i] + RW'(1);
                        end
                     end
                     rank_in[f_idx]  = '0;
                     valid_in[f_idx] = 1'b1;
                     tag_we          = 1'b1;
                     held_in         = held_ff + CW'(1);
                     exec_done       = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = lhc_pkg::RSP_INSERT;
                     rsp_slot_in     = f_idx;
                     rsp_x_in        = cur_ff.key_x;
                     rsp_z_in        = cur_ff.key_z;
                     rsp_count_in    = held_in;
                  end else begin
                     exec_done     = 1'b1;
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = lhc_pkg::RSP_OPEN_FAIL;
                     rsp_x_in      = cur_ff.key_x;
                     rsp_z_in      = cur_ff.key_z;
                  end
               end
               lhc_pkg::REQ_TRIM: begin
                  if (held_ff > cap_eff) begin
                     if (v_found) begin
                        valid_in[v_idx] = 1'b0;
                        rank_in[v_idx]  = '0;
                        held_in         = held_ff - CW'(1);
                        rsp_valid_in    = 1'b1;
                        rsp_status_in   = lhc_pkg::RSP_EVICT;
                        rsp_slot_in     = v_idx;
                        rsp_x_in        = tag_x_ff[v_idx];
                        rsp_z_in        = tag_z_ff[v_idx];
                        rsp_last_in     = 1'b0;
                        rsp_count_in    = held_in;
                     end else begin
                        held_in = '0;
                     end
                  end else begin
                     exec_done    = 1'b1;
                     rsp_valid_in = 1'b1;
                  end
               end
               lhc_pkg::REQ_CLEAR: begin
                  valid_in = '0;
                  for (int i = 0; i < N; i++) begin
                     rank_in[i] = '0;
                  end
                  held_in      = '0;
                  exec_done    = 1'b1;
                  rsp_valid_in = 1'b1;
                  rsp_count_in = '0;
               end
               default: begin
                  exec_done    = 1'b1;
                  rsp_valid_in = 1'b1;
               end
            endcase
            if (exec_done && !q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_head;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lhc_pkg::ST_IDLE;
         valid_ff     <= '0;
         held_ff      <= '0;
         cap_ff       <= lhc_pkg::CapReset;
         hit_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < N; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         held_ff      <= held_in;
         hit_ff       <= hit_in;
         rsp_valid_ff <= rsp_valid_in;
         rank_ff      <= rank_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      hit_idx_ff    <= hit_idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_z_ff      <= rsp_z_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (tag_we) begin
         tag_x_ff[tag_idx] <= cur_ff.key_x;
         tag_z_ff[tag_idx] <= cur_ff.key_z;
      end
   end

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the LRU handle cache. A directed table covers
// empty-cache requests, extreme keys, hits, fills, evictions and the
// capacity corner values. Random phases follow, each with its chosen capacity and
// sender gap rate. Every accepted request runs through an LRU predictor, and
// the result words are compared field by field in order.
// ----------------------------------------------------------------------------
module tb_top;

   localparam logic [lhc_pkg::KeyW-1:0] KMin  = 32'h8000_0000;
   localparam logic [lhc_pkg::KeyW-1:0] KMax  = 32'h7fff_ffff;
   localparam logic [lhc_pkg::KeyW-1:0] KOnes = 32'hffff_ffff;
   localparam int NumPhases    = 10;
   localparam int PhaseItems   = 50;
   localparam int SettleCycles = 12;
   localparam int MaxGap       = 6;
   localparam int NumRows      = 26;

   typedef struct packed {
      lhc_pkg::status_type        status;
      logic [lhc_pkg::SlotW-1:0]  slot;
      logic [lhc_pkg::KeyW-1:0]   x;
      logic [lhc_pkg::KeyW-1:0]   z;
      logic [lhc_pkg::CountW-1:0] count;
      logic                       last;
   } rsp_word_type;

   typedef struct packed {
      logic                       cfg;
      lhc_pkg::req_code_type      op;
      logic [lhc_pkg::KeyW-1:0]   kx;
      logic [lhc_pkg::KeyW-1:0]   kz;
      logic                       ok;
      logic                       typed;
      lhc_pkg::status_type        st;
      logic [lhc_pkg::SlotW-1:0]  slot;
      logic [lhc_pkg::CountW-1:0] cnt;
   } dir_row_type;

   typedef struct packed {
      logic         typed;
      rsp_word_type w;
   } typed_word_type;

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [1:0]                        req_type;
   logic signed [lhc_pkg::KeyW-1:0]   req_key_x;
   logic signed [lhc_pkg::KeyW-1:0]   req_key_z;
   logic                              req_open_ok;
   logic                              csr_wr_en;
   logic [lhc_pkg::CountW-1:0]        csr_wr_data;
   logic                              rsp_valid;
   logic [2:0]                        rsp_status;
   logic [lhc_pkg::SlotW-1:0]         rsp_slot;
   logic signed [lhc_pkg::KeyW-1:0]   rsp_out_x;
   logic signed [lhc_pkg::KeyW-1:0]   rsp_out_z;
   logic [lhc_pkg::CountW-1:0]        rsp_entry_count;
   logic                              rsp_last;

   // predictor state
   logic [lhc_pkg::KeyW-1:0]   held_x   [lhc_pkg::NumSlots];
   logic [lhc_pkg::KeyW-1:0]   held_z   [lhc_pkg::NumSlots];
   logic                       held_on  [lhc_pkg::NumSlots];
   logic [lhc_pkg::RankW-1:0]  held_age [lhc_pkg::NumSlots];
   int                         held_n;
   logic [lhc_pkg::CountW-1:0] cap_reg;

   rsp_word_type   words_due [$];
   typed_word_type typed_due [$];

   int err_count = 0;
   int n_items   = 0;
   int n_evict   = 0;
   int n_hit     = 0;
   int n_insert  = 0;
   int n_fail    = 0;
   int n_done    = 0;

   // cfg, op, key_x, key_z, open_ok, typed, status, slot, count
   dir_row_type dir_tab [NumRows] = '{
      '{1'b0, lhc_pkg::REQ_TRIM,   32'd0, 32'd0, 1'b0, 1'b1, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_CLEAR,  32'd0, 32'd0, 1'b0, 1'b1, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_NOP,    KOnes, KOnes, 1'b1, 1'b1, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, KMin,  KMax,  1'b0, 1'b1,
        lhc_pkg::RSP_OPEN_FAIL, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, KMin,  KMax,  1'b1, 1'b1, lhc_pkg::RSP_INSERT, 3'd0, 4'd1},
      '{1'b0, lhc_pkg::REQ_ACCESS, KMin,  KMax,  1'b0, 1'b1, lhc_pkg::RSP_HIT,    3'd0, 4'd1},
      '{1'b0, lhc_pkg::REQ_ACCESS, KMax,  KMin,  1'b1, 1'b1, lhc_pkg::RSP_INSERT, 3'd1, 4'd2},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd0, 32'd0, 1'b1, 1'b1, lhc_pkg::RSP_INSERT, 3'd2, 4'd3},
      '{1'b0, lhc_pkg::REQ_ACCESS, KOnes, KOnes, 1'b1, 1'b1, lhc_pkg::RSP_INSERT, 3'd3, 4'd4},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd1, 32'd2, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd3, 32'd4, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd5, 32'd6, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd7, 32'd8, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, KMin,  KMax,  1'b1, 1'b1, lhc_pkg::RSP_HIT,    3'd0, 4'd8},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd9, 32'd9, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd10, 32'd10, 1'b0, 1'b0, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b1, lhc_pkg::REQ_NOP,    32'd3, 32'd0, 1'b0, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_TRIM,   32'd0, 32'd0, 1'b0, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd0, 32'd0, 1'b1, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b1, lhc_pkg::REQ_NOP,    32'd0, 32'd0, 1'b0, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd11, 32'd11, 1'b1, 1'b0, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd12, 32'd12, 1'b0, 1'b0, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b1, lhc_pkg::REQ_NOP,    32'd15, 32'd0, 1'b0, 1'b0, lhc_pkg::RSP_DONE,  3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_ACCESS, 32'd11, 32'd11, 1'b1, 1'b0, lhc_pkg::RSP_DONE, 3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_TRIM,   32'd0, 32'd0, 1'b0, 1'b0, lhc_pkg::RSP_DONE,   3'd0, 4'd0},
      '{1'b0, lhc_pkg::REQ_CLEAR,  KMax,  KMin,  1'b1, 1'b1, lhc_pkg::RSP_DONE,   3'd0, 4'd0}
   };

   lru_handle_cache dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_type        (req_type),
      .req_key_x       (req_key_x),
      .req_key_z       (req_key_z),
      .req_open_ok     (req_open_ok),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_z       (rsp_out_z),
      .rsp_entry_count (rsp_entry_count),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   task automatic owe_word(input lhc_pkg::status_type st, input int slot,
                           input logic [lhc_pkg::KeyW-1:0] x,
                           input logic [lhc_pkg::KeyW-1:0] z,
                           input logic lst);
      rsp_word_type w;
      w.status = st;
      w.slot   = slot[lhc_pkg::SlotW-1:0];
      w.x      = x;
      w.z      = z;
      w.count  = held_n[lhc_pkg::CountW-1:0];
      w.last   = lst;
      words_due.push_back(w);
   endtask

   task automatic evict_lru();
      int v;
      v = -1;
      for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
         if (held_on[i] && (v < 0 || held_age[i] > held_age[v])) v = i;
      end
      if (v < 0) begin
         held_n = 0;
      end else begin
         held_on[v]  = 1'b0;
         held_age[v] = '0;
         held_n--;
         owe_word(lhc_pkg::RSP_EVICT, v, held_x[v], held_z[v], 1'b0);
      end
   endtask

   task automatic cache_apply_req(input lhc_pkg::req_code_type op,
                                  input logic [lhc_pkg::KeyW-1:0] kx,
                                  input logic [lhc_pkg::KeyW-1:0] kz, input logic ok);
      int cap;
      int hit;
      int slot;
      logic [lhc_pkg::RankW-1:0] r;
      cap  = (cap_reg > lhc_pkg::NumSlots) ? lhc_pkg::NumSlots : int'(cap_reg);
      hit  = -1;
      slot = -1;
      case (op)
         lhc_pkg::REQ_ACCESS: begin
            for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
               if (hit < 0 && held_on[i] && held_x[i] == kx && held_z[i] == kz) hit = i;
            end
            if (hit >= 0) begin
               r = held_age[hit];
               for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
                  if (held_on[i] && held_age[i] < r) held_age[i]++;
               end
               held_age[hit] = '0;
               owe_word(lhc_pkg::RSP_HIT, hit, kx, kz, 1'b1);
            end else begin
               while (held_n > 0 && held_n >= cap) evict_lru();
               if (ok) begin
                  for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
                     if (slot < 0 && !held_on[i]) slot = i;
                  end
               end
               if (slot >= 0) begin
                  for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
                     if (held_on[i]) held_age[i]++;
                  end
                  held_on[slot]  = 1'b1;
                  held_age[slot] = '0;
                  held_x[slot]   = kx;
                  held_z[slot]   = kz;
                  held_n++;
                  owe_word(lhc_pkg::RSP_INSERT, slot, kx, kz, 1'b1);
               end else begin
                  owe_word(lhc_pkg::RSP_OPEN_FAIL, 0, kx, kz, 1'b1);
               end
            end
         end
         lhc_pkg::REQ_TRIM: begin
            while (held_n > cap) evict_lru();
            owe_word(lhc_pkg::RSP_DONE, 0, '0, '0, 1'b1);
         end
         lhc_pkg::REQ_CLEAR: begin
            for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
               held_on[i]  = 1'b0;
               held_age[i] = '0;
            end
            held_n = 0;
            owe_word(lhc_pkg::RSP_DONE, 0, '0, '0, 1'b1);
         end
         default: begin
            owe_word(lhc_pkg::RSP_DONE, 0, '0, '0, 1'b1);
         end
      endcase
   endtask

   task automatic check_field(input string fld, input logic [lhc_pkg::KeyW-1:0] exp_v,
                              input logic [lhc_pkg::KeyW-1:0] act_v);
      if (act_v !== exp_v) begin
         err_count++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, fld, exp_v, act_v);
      end
   endtask

   always @(posedge clock) begin
      rsp_word_type   w;
      typed_word_type t;
      if (reset) begin
         for (int i = 0; i < lhc_pkg::NumSlots; i++) begin
            held_on[i]  = 1'b0;
            held_age[i] = '0;
         end
         held_n  = 0;
         cap_reg = lhc_pkg::CapReset;
      end else begin
         if (rsp_valid) begin
            if (words_due.size() == 0) begin
               err_count++;
               $display("%0t: unexpected result word, status %0d slot %0d", $time,
                        rsp_status, rsp_slot);
            end else begin
               w = words_due.pop_front();
               check_field("status", lhc_pkg::KeyW'(w.status), lhc_pkg::KeyW'(rsp_status));
               check_field("slot", lhc_pkg::KeyW'(w.slot), lhc_pkg::KeyW'(rsp_slot));
               check_field("out_x", w.x, rsp_out_x);
               check_field("out_z", w.z, rsp_out_z);
               check_field("entry_count", lhc_pkg::KeyW'(w.count),
                           lhc_pkg::KeyW'(rsp_entry_count));
               check_field("last", lhc_pkg::KeyW'(w.last), lhc_pkg::KeyW'(rsp_last));
               case (w.status)
                  lhc_pkg::RSP_EVICT:     n_evict++;
                  lhc_pkg::RSP_HIT:       n_hit++;
                  lhc_pkg::RSP_INSERT:    n_insert++;
                  lhc_pkg::RSP_OPEN_FAIL: n_fail++;
                  default:                n_done++;
               endcase
            end
         end
         if (csr_wr_en) cap_reg = csr_wr_data;
         if (start && !busy) begin
            n_items++;
            cache_apply_req(lhc_pkg::req_code_type'(req_type), req_key_x, req_key_z,
                            req_open_ok);
            if (typed_due.size() != 0) begin
               t = typed_due.pop_front();
               if (t.typed) begin
                  words_due[words_due.size() - 1] = t.w;
               end
            end
         end
      end
   end

   task automatic send_word(input lhc_pkg::req_code_type op,
                            input logic [lhc_pkg::KeyW-1:0] kx,
                            input logic [lhc_pkg::KeyW-1:0] kz, input logic ok);
      start       <= 1'b1;
      req_type    <= op;
      req_key_x   <= kx;
      req_key_z   <= kz;
      req_open_ok <= ok;
      do @(posedge clock); while (busy);
   endtask

   task automatic take_break(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, MaxGap)) @(posedge clock);
      end
   endtask

   task automatic wait_quiet();
      start <= 1'b0;
      do @(posedge clock); while (words_due.size() != 0);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic set_capacity(input logic [lhc_pkg::CountW-1:0] v);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      logic [lhc_pkg::CountW-1:0] caps      [NumPhases];
      int                         idle_plan [NumPhases];
      logic [lhc_pkg::KeyW-1:0]   pool_x    [lhc_pkg::NumSlots + 3];
      logic [lhc_pkg::KeyW-1:0]   pool_z    [lhc_pkg::NumSlots + 3];
      logic [lhc_pkg::KeyW-1:0]   kx;
      logic [lhc_pkg::KeyW-1:0]   kz;
      lhc_pkg::req_code_type      op;
      typed_word_type             t;
      int                         pool_n;
      int                         pick;
      int                         r;

      reset       <= 1'b1;
      start       <= 1'b0;
      req_type    <= lhc_pkg::REQ_ACCESS;
      req_key_x   <= '0;
      req_key_z   <= '0;
      req_open_ok <= 1'b0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) begin
         if (dir_tab[i].cfg) begin
            set_capacity(dir_tab[i].kx[lhc_pkg::CountW-1:0]);
         end else begin
            t.typed    = dir_tab[i].typed;
            t.w.status = dir_tab[i].st;
            t.w.slot   = dir_tab[i].slot;
            t.w.x      = (dir_tab[i].st == lhc_pkg::RSP_DONE) ? '0 : dir_tab[i].kx;
            t.w.z      = (dir_tab[i].st == lhc_pkg::RSP_DONE) ? '0 : dir_tab[i].kz;
            t.w.count  = dir_tab[i].cnt;
            t.w.last   = 1'b1;
            typed_due.push_back(t);
            send_word(dir_tab[i].op, dir_tab[i].kx, dir_tab[i].kz, dir_tab[i].ok);
            take_break(25);
         end
      end

      caps      = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd7, 4'd2, 4'd11, 4'd5, 4'd8};
      caps[6]   = lhc_pkg::CountW'($urandom_range(2, 6));
      caps[7]   = lhc_pkg::CountW'($urandom_range(9, 14));
      idle_plan = '{0, 78, 18, 78, 0, 18, 78, 18, 0, 78};

      for (int ph = 0; ph < NumPhases; ph++) begin
         set_capacity(caps[ph]);
         pool_n = ((caps[ph] > lhc_pkg::NumSlots) ? lhc_pkg::NumSlots : int'(caps[ph])) + 3;
         for (int k = 0; k < pool_n; k++) begin
            pool_x[k] = $urandom;
            pool_z[k] = $urandom;
            // share one coordinate with the previous key now and then
            if (k > 0 && $urandom_range(1) == 0) pool_x[k] = pool_x[k-1];
         end
         repeat (PhaseItems) begin
            r  = $urandom_range(99);
            op = (r < 84) ? lhc_pkg::REQ_ACCESS :
                 (r < 92) ? lhc_pkg::REQ_TRIM :
                 (r < 96) ? lhc_pkg::REQ_CLEAR : lhc_pkg::REQ_NOP;
            pick = $urandom_range(pool_n - 1);
            if ($urandom_range(99) < 85) begin
               kx = pool_x[pick];
               kz = pool_z[pick];
            end else begin
               kx = $urandom;
               kz = $urandom;
            end
            send_word(op, kx, kz, $urandom_range(99) < 85);
            take_break(idle_plan[ph]);
         end
      end

      wait_quiet();
      $display("tb_top: %0d requests; %0d hits, %0d inserts, %0d failed opens, %0d evictions",
               n_items, n_hit, n_insert, n_fail, n_evict);
      $display("tb_top: %0d trim/clear/nop words; capacities 0 to 15 over %0d random phases",
               n_done, NumPhases);
      if (err_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("%0t: timeout, %0d words still due", $time, words_due.size());
      $display("tb_top: done, errors");
      $finish;
   end

endmodule
